FILE: hdl/rtt_pkg.sv
// Package for the retry task table: opcodes, status codes, entry record,
// sequencer states and the backoff helper. Depends on nothing.
package rtt_pkg;

   localparam int unsigned BACKOFF_CAP = 60000;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_PROCESS = 3'd1,
      OP_REPORT  = 3'd2,
      OP_CANCEL  = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_QUERY   = 3'd5
   } op_type;

   localparam logic [2:0] ST_PENDING   = 3'd0;
   localparam logic [2:0] ST_RUNNING   = 3'd1;
   localparam logic [2:0] ST_SUCCESS   = 3'd2;
   localparam logic [2:0] ST_FAILED    = 3'd3;
   localparam logic [2:0] ST_RETRYING  = 3'd4;
   localparam logic [2:0] ST_CANCELLED = 3'd5;

   localparam logic [1:0] REG_BACKOFF  = 2'd0;
   localparam logic [1:0] REG_INTERVAL = 2'd1;
   localparam logic [1:0] REG_CRIT     = 2'd2;

   // one table entry as stored in memory
   typedef struct packed {
      logic [3:0]  ttype;
      logic [7:0]  limit;
      logic [23:0] base;
      logic [2:0]  status;
      logic [7:0]  attempts;
      logic [31:0] next_time;
      logic [31:0] last_attempt;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,      // read address issued, wait for data
      S_EXAM,    // data valid, act on it
      S_BACK,    // backoff doubling steps
      S_RUNREQ,  // run request waits in output register
      S_SUM,     // final summary walk
      S_SUMRD,
      S_REPLY
   } state_type;

   // one backoff doubling of the interval, capped at BACKOFF_CAP; one compare per step
   function automatic logic [31:0] backoff_step(input logic [31:0] v);
      logic [32:0] d;
      d = {v, 1'b0};
      backoff_step = (d > 33'(BACKOFF_CAP)) ? 32'(BACKOFF_CAP) : d[31:0];
   endfunction

endpackage

FILE: hdl/rtt_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on nothing.
interface rtt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [3:0]  task_type;
   logic [7:0]  max_attempts;
   logic [23:0] base_interval;
   logic [31:0] now;
   logic        success;
   modport source (output valid, op, task_type, max_attempts, base_interval, now,
                   success, input ready);
   modport sink   (input valid, op, task_type, max_attempts, base_interval, now,
                   success, output ready);
endinterface

interface rtt_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [3:0] task_type_res;
   logic [2:0] status;
   logic [7:0] attempt;
   logic [3:0] active_count;
   logic       critical_failure;
   logic       queue_full;
   logic       last;
   modport source (output valid, kind, task_type_res, status, attempt, active_count,
                   critical_failure, queue_full, last, input ready);
   modport sink   (input valid, kind, task_type_res, status, attempt, active_count,
                   critical_failure, queue_full, last, output ready);
endinterface

interface rtt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rtt_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hdl/retry_task_table_with_backoff.sv
// Top level of the retry task table: sequencer around one entry memory.
// Depends on rtt_pkg, rtt_if and rtt_ram.
//
//  channel | dir | carries
//  req     | in  | op, task_type, max_attempts, base_interval, now, success
//  rsp     | out | kind, task_type_res, status, attempt, counts, flags, last
//  csr     | in  | index, data (register writes)
//
// An operation walks the used part of the table (N entries) one entry at a time
// (S_RD issues the read, S_EXAM acts on the data); a throttled process or an
// unknown op skips that walk. All then walk again to total active and critical
// entries. A run request waits in S_RUNREQ; a failed report doubles its backoff
// in S_BACK (at most 16 doublings before the cap for a nonzero base, up to 254
// for a zero base). Compaction moves entries down during the walk.
// Reset clears the fill count and scan time; entries beyond the count are never
// read. A stalled response holds the sequencer.
module retry_task_table_with_backoff #(
   parameter int TABLE_DEPTH = 8
) (
   input logic clock,
   input logic reset,
   rtt_req_if.sink   req,
   rtt_rsp_if.source rsp,
   rtt_csr_if.sink   csr
);
   import rtt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // configuration
   logic        backoff_ff;
   logic [15:0] interval_ff;
   logic [15:0] crit_mask_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         backoff_ff   <= 1'b0;
         interval_ff  <= 16'd1000;
         crit_mask_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_BACKOFF:  backoff_ff   <= csr.data[0];
            REG_INTERVAL: interval_ff  <= csr.data;
            REG_CRIT:     crit_mask_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // state
   state_type   state_ff, state_in;
   logic [CW-1:0] used_ff, used_in;
   logic [31:0] scan_ff, scan_in;
   logic [CW-1:0] rd_ff, rd_in;   // read pointer
   logic [CW-1:0] wr_ff, wr_in;   // compaction write pointer
   logic [2:0]  op_ff;
   logic [3:0]  type_ff;
   logic [7:0]  lim_ff;
   logic [23:0] base_ff;
   logic [31:0] now_ff;
   logic        ok_ff;
   logic        scan_en_ff, scan_en_in;
   logic        found_ff, found_in;
   logic [2:0]  st_ff, st_in;
   logic [7:0]  att_ff, att_in;
   logic        full_ff, full_in;
   logic [CW-1:0] act_ff, act_in;
   logic        crit_ff, crit_in;
   logic [31:0] bo_ff, bo_in;
   logic [7:0]  bo_k_ff, bo_k_in;
   entry_type   hold_ff, hold_in;

   // response register
   logic        rv_ff, rv_in;
   logic        rkind_ff, rkind_in, rlast_ff, rlast_in;
   logic [3:0]  rtype_ff, rtype_in;
   logic [2:0]  rst_ff, rst_in;
   logic [7:0]  ratt_ff, ratt_in;

   // memory
   logic          we;
   logic [AW-1:0] wa, ra;
   entry_type     wd, rdat;
   logic [ENTRY_W-1:0] rdat_raw;

   rtt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(wa),
      .wr_data(wd),
      .rd_addr(ra),
      .rd_data(rdat_raw)
   );
   assign rdat = entry_type'(rdat_raw);

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.kind = rkind_ff;
   assign rsp.task_type_res = rtype_ff;
   assign rsp.status = rst_ff;
   assign rsp.attempt = ratt_ff;
   assign rsp.active_count = rkind_ff ? 4'd0 : 4'(act_ff);
   assign rsp.critical_failure = rkind_ff ? 1'b0 : crit_ff;
   assign rsp.queue_full = rkind_ff ? 1'b0 : full_ff;
   assign rsp.last = rlast_ff;

   logic fin;
   logic keep;
   logic [31:0] nxt;

   always_comb begin
      state_in = state_ff; used_in = used_ff; scan_in = scan_ff;
      rd_in = rd_ff; wr_in = wr_ff; scan_en_in = scan_en_ff;
      found_in = found_ff; st_in = st_ff; att_in = att_ff; full_in = full_ff;
      act_in = act_ff; crit_in = crit_ff; bo_in = bo_ff; bo_k_in = bo_k_ff;
      hold_in = hold_ff;
      rv_in = rv_ff; rkind_in = rkind_ff; rlast_in = rlast_ff; rtype_in = rtype_ff;
      rst_in = rst_ff; ratt_in = ratt_ff;
      we = 1'b0; wa = AW'(wr_ff); wd = rdat; ra = AW'(rd_ff);
      fin = 1'b0; keep = 1'b1; nxt = '0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               rd_in = '0; wr_in = '0; found_in = 1'b0;
               st_in = ST_PENDING; att_in = '0; full_in = 1'b0;
               scan_en_in = (req.now - scan_ff) >= 32'(interval_ff);
               if (req.op == OP_PROCESS && scan_en_in) scan_in = req.now;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (rd_ff >= used_ff || op_ff > OP_QUERY
                || (op_ff == OP_PROCESS && !scan_en_ff)) begin
               // walk over: wrap up the operation
               if (op_ff == OP_ADD || op_ff == OP_CLEAR) used_in = wr_ff;
               if (op_ff == OP_ADD) begin
                  if (wr_ff >= CW'(TABLE_DEPTH)) begin
                     full_in = 1'b1; st_in = ST_FAILED;
                  end else begin
                     we = 1'b1; wa = AW'(wr_ff);
                     wd = '{ttype: type_ff, limit: lim_ff, base: base_ff,
                            status: ST_PENDING, attempts: 8'd0, next_time: now_ff,
                            last_attempt: 32'd0};
                     used_in = wr_ff + 1'b1;
                  end
               end else if ((op_ff == OP_REPORT || op_ff == OP_CANCEL
                             || op_ff == OP_QUERY) && !found_ff) begin
                  st_in = ST_FAILED;
               end
               rd_in = '0; act_in = '0; crit_in = 1'b0;
               state_in = S_SUM;
            end else begin
               state_in = S_EXAM;
            end
         end
         S_EXAM: begin
            hold_in = rdat;
            rd_in = rd_ff + 1'b1;
            state_in = S_RD;
            unique case (op_ff)
               OP_ADD, OP_CLEAR: begin
                  if (op_ff == OP_ADD) keep = rdat.ttype != type_ff;
                  else keep = !(rdat.status == ST_SUCCESS || rdat.status == ST_FAILED
                                || rdat.status == ST_CANCELLED);
                  if (keep) begin
                     we = (wr_ff != rd_ff); wa = AW'(wr_ff); wd = rdat;
                     wr_in = wr_ff + 1'b1;
                  end
               end
               OP_PROCESS: begin
                  if (!(rdat.status == ST_SUCCESS || rdat.status == ST_CANCELLED
                        || rdat.status == ST_RUNNING) && now_ff >= rdat.next_time) begin
                     we = 1'b1; wa = AW'(rd_ff); wd = rdat;
                     if (rdat.attempts >= rdat.limit) begin
                        wd.status = ST_FAILED;
                     end else begin
                        wd.attempts = rdat.attempts + 8'd1;
                        wd.status = ST_RUNNING;
                        wd.last_attempt = now_ff;
                        rv_in = 1'b1; rkind_in = 1'b1; rlast_in = 1'b0;
                        rtype_in = rdat.ttype; rst_in = ST_RUNNING;
                        ratt_in = rdat.attempts + 8'd1;
                        state_in = S_RUNREQ;
                     end
                  end
               end
               OP_REPORT, OP_CANCEL, OP_QUERY: begin
                  if (!found_ff && rdat.ttype == type_ff) begin
                     found_in = 1'b1;
                     st_in = rdat.status; att_in = rdat.attempts;
                     if (op_ff == OP_CANCEL) begin
                        we = 1'b1; wa = AW'(rd_ff); wd = rdat;
                        wd.status = ST_CANCELLED; st_in = ST_CANCELLED;
                     end else if (op_ff == OP_REPORT && rdat.status == ST_RUNNING) begin
                        if (ok_ff) begin
                           we = 1'b1; wa = AW'(rd_ff); wd = rdat;
                           wd.status = ST_SUCCESS; st_in = ST_SUCCESS;
                        end else begin
                           st_in = ST_RETRYING;
                           bo_in = 32'(rdat.base); bo_k_in = 8'd1;
                           state_in = S_BACK;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         S_BACK: begin
            // one doubling per cycle while backoff is enabled, until attempts reached or capped
            if (backoff_ff && bo_k_ff < hold_ff.attempts
                && bo_ff != 32'(BACKOFF_CAP)) begin
               bo_in = backoff_step(bo_ff);
               bo_k_in = bo_k_ff + 8'd1;
            end else begin
               nxt = hold_ff.last_attempt + bo_ff;
               we = 1'b1; wa = AW'(rd_ff - 1'b1); wd = hold_ff;
               wd.status = ST_RETRYING; wd.next_time = nxt;
               state_in = S_RD;
            end
         end
         S_RUNREQ: begin
            if (!rv_ff || rsp.ready) state_in = S_RD;
         end
         S_SUM: begin
            if (rd_ff >= used_ff) begin
               if (!rv_ff || rsp.ready) begin
                  rv_in = 1'b1; rkind_in = 1'b0; rlast_in = 1'b1;
                  rtype_in = (op_ff == OP_PROCESS || op_ff == OP_CLEAR
                              || op_ff > OP_QUERY) ? 4'd0 : type_ff;
                  rst_in = st_ff; ratt_in = att_ff;
                  state_in = S_REPLY;
               end
            end else begin
               state_in = S_SUMRD;
            end
         end
         S_SUMRD: begin
            fin = (rdat.status == ST_SUCCESS || rdat.status == ST_CANCELLED);
            if (!fin) act_in = act_ff + 1'b1;
            if (rdat.status == ST_FAILED && crit_mask_ff[rdat.ttype]) crit_in = 1'b1;
            rd_in = rd_ff + 1'b1;
            state_in = S_SUM;
         end
         S_REPLY: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         scan_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         scan_ff  <= scan_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req.valid) begin
         op_ff <= req.op; type_ff <= req.task_type; lim_ff <= req.max_attempts;
         base_ff <= req.base_interval; now_ff <= req.now; ok_ff <= req.success;
      end
      rd_ff <= rd_in; wr_ff <= wr_in; scan_en_ff <= scan_en_in;
      found_ff <= found_in; st_ff <= st_in; att_ff <= att_in; full_ff <= full_in;
      act_ff <= act_in; crit_ff <= crit_in; bo_ff <= bo_in; bo_k_ff <= bo_k_in;
      hold_ff <= hold_in;
      rkind_ff <= rkind_in; rlast_ff <= rlast_in; rtype_ff <= rtype_in;
      rst_ff <= rst_in; ratt_ff <= ratt_in;
   end

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(TABLE_DEPTH)) else $error("fill count beyond table depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("request taken while busy");
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rkind_ff) |-> rlast_ff) else $error("status reply without last");
   a_runreq_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp.ready) |=> rv_ff && $stable(rtype_ff))
      else $error("response dropped under stall");
endmodule

FILE: dv/tb_retry_task_table_with_backoff.sv
// Testbench for the retry task table: directed and random requests against a
// behavioral scoreboard of the table. Depends on rtt_pkg, rtt_if and the RTL.
module tb_retry_task_table_with_backoff;
   timeunit 1ns;
   timeprecision 1ps;
   import rtt_pkg::*;

   localparam int DEPTH = 8;
   localparam int MAX_CYCLES = 2000000;

   logic clock;
   logic reset;

   rtt_req_if req ();
   rtt_rsp_if rsp ();
   rtt_csr_if csr ();

   retry_task_table_with_backoff #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // one expected response
   typedef struct packed {
      logic       kind;
      logic [3:0] ttype;
      logic [2:0] status;
      logic [7:0] attempt;
      logic [3:0] active;
      logic       crit;
      logic       full;
      logic       last;
   } rsp_item_t;

   // scoreboard copy of the table
   logic [3:0]  tbl_type [DEPTH];
   logic [7:0]  tbl_limit [DEPTH];
   logic [23:0] tbl_base [DEPTH];
   logic [2:0]  tbl_status [DEPTH];
   logic [7:0]  tbl_att [DEPTH];
   logic [31:0] tbl_next [DEPTH];
   logic [31:0] tbl_last [DEPTH];
   int          tbl_used;
   logic [31:0] scan_time;
   logic        cfg_backoff;
   logic [15:0] cfg_interval;
   logic [15:0] cfg_crit_mask;

   rsp_item_t expected_q[$];
   int        mismatches;
   int        cycles;
   int        send_idle_pct;
   int        recv_idle_pct;
   int        hold_cycles;
   logic [31:0] clk_now;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver ready: random stalls plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_item_t got, exp_item;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.kind, rsp.task_type_res, rsp.status, rsp.attempt, rsp.active_count,
                 rsp.critical_failure, rsp.queue_full, rsp.last};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp_item = expected_q.pop_front();
            if (got !== exp_item) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp kind %0d type %0d st %0d att %0d act %0d crit %0d full %0d last %0d / got kind %0d type %0d st %0d att %0d act %0d crit %0d full %0d last %0d",
                     exp_item.kind, exp_item.ttype, exp_item.status, exp_item.attempt,
                     exp_item.active, exp_item.crit, exp_item.full, exp_item.last,
                     got.kind, got.ttype, got.status, got.attempt, got.active, got.crit,
                     got.full, got.last);
            end
         end
      end
   end

   function automatic void move_row(int dst, int src);
      tbl_type[dst] = tbl_type[src];
      tbl_limit[dst] = tbl_limit[src];
      tbl_base[dst] = tbl_base[src];
      tbl_status[dst] = tbl_status[src];
      tbl_att[dst] = tbl_att[src];
      tbl_next[dst] = tbl_next[src];
      tbl_last[dst] = tbl_last[src];
   endfunction

   // drop rows of one type, or finished rows
   function automatic void compact_table(bit finished, logic [3:0] t);
      int w;
      bit keep;
      w = 0;
      for (int r = 0; r < tbl_used; r++) begin
         if (!finished) keep = tbl_type[r] != t;
         else keep = !(tbl_status[r] inside {ST_SUCCESS, ST_FAILED, ST_CANCELLED});
         if (keep) begin
            if (w != r) move_row(w, r);
            w++;
         end
      end
      tbl_used = w;
   endfunction

   function automatic logic [31:0] retry_gap(int i);
      logic [63:0] v;
      v = tbl_base[i];
      if (!cfg_backoff) return v[31:0];
      for (int k = 1; k < tbl_att[i]; k++) begin
         v = v * 2;
         if (v > BACKOFF_CAP) return BACKOFF_CAP;
      end
      return v[31:0];
   endfunction

   // apply one request to the scoreboard and queue its responses
   function automatic void predict_request(logic [2:0] op, logic [3:0] t, logic [7:0] lim,
                                           logic [23:0] base, logic [31:0] now_v,
                                           logic ok);
      rsp_item_t r;
      int e;
      r = '0;
      r.last = 1'b1;
      if (op == OP_ADD) begin
         r.ttype = t;
         compact_table(1'b0, t);
         if (tbl_used >= DEPTH) begin
            r.full = 1'b1;
            r.status = ST_FAILED;
         end else begin
            tbl_type[tbl_used] = t;
            tbl_limit[tbl_used] = lim;
            tbl_base[tbl_used] = base;
            tbl_status[tbl_used] = ST_PENDING;
            tbl_att[tbl_used] = '0;
            tbl_next[tbl_used] = now_v;
            tbl_last[tbl_used] = '0;
            tbl_used++;
            r.status = ST_PENDING;
         end
      end else if (op == OP_PROCESS) begin
         if (now_v - scan_time >= {16'd0, cfg_interval}) begin
            scan_time = now_v;
            for (int i = 0; i < tbl_used; i++) begin
               rsp_item_t q;
               if (tbl_status[i] inside {ST_SUCCESS, ST_CANCELLED, ST_RUNNING}) continue;
               if (now_v < tbl_next[i]) continue;
               if (tbl_att[i] >= tbl_limit[i]) begin
                  tbl_status[i] = ST_FAILED;
                  continue;
               end
               tbl_att[i] = tbl_att[i] + 8'd1;
               tbl_status[i] = ST_RUNNING;
               tbl_last[i] = now_v;
               q = '0;
               q.kind = 1'b1;
               q.ttype = tbl_type[i];
               q.status = ST_RUNNING;
               q.attempt = tbl_att[i];
               expected_q.push_back(q);
            end
         end
      end else if (op == OP_REPORT || op == OP_CANCEL || op == OP_QUERY) begin
         r.ttype = t;
         e = -1;
         for (int i = 0; i < tbl_used; i++)
            if (e < 0 && tbl_type[i] == t) e = i;
         if (e < 0) begin
            r.status = ST_FAILED;
         end else begin
            if (op == OP_REPORT && tbl_status[e] == ST_RUNNING) begin
               if (ok) tbl_status[e] = ST_SUCCESS;
               else begin
                  tbl_status[e] = ST_RETRYING;
                  tbl_next[e] = tbl_last[e] + retry_gap(e);
               end
            end else if (op == OP_CANCEL) begin
               tbl_status[e] = ST_CANCELLED;
            end
            r.status = tbl_status[e];
            r.attempt = tbl_att[e];
         end
      end else if (op == OP_CLEAR) begin
         compact_table(1'b1, '0);
      end
      for (int i = 0; i < tbl_used; i++) begin
         if (!(tbl_status[i] inside {ST_SUCCESS, ST_CANCELLED})) r.active++;
         if (tbl_status[i] == ST_FAILED && cfg_crit_mask[tbl_type[i]]) r.crit = 1'b1;
      end
      expected_q.push_back(r);
   endfunction

   // send one request; predicts at acceptance
   task automatic send_request(logic [2:0] op, logic [3:0] t, logic [7:0] lim,
                               logic [23:0] base, logic [31:0] now_v, logic ok);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req.valid <= 1'b1;
      req.op <= op;
      req.task_type <= t;
      req.max_attempts <= lim;
      req.base_interval <= base;
      req.now <= now_v;
      req.success <= ok;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_request(op, t, lim, base, now_v, ok);
      @(negedge clock);
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // register write while idle
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (idx)
         REG_BACKOFF:  cfg_backoff = val[0];
         REG_INTERVAL: cfg_interval = val;
         REG_CRIT:     cfg_crit_mask = val;
         default: ;
      endcase
      @(negedge clock);
      csr.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic tick(logic [31:0] step);
      clk_now = clk_now + step;
      send_request(OP_PROCESS, 4'($urandom), 8'($urandom), 24'($urandom), clk_now,
                   1'($urandom));
   endtask

   // directed: extremes, every operation, special cases
   task automatic test_directed();
      write_reg(REG_INTERVAL, 16'd0);
      write_reg(REG_CRIT, 16'hFFFF);
      write_reg(REG_BACKOFF, 16'd1);
      clk_now = 32'd100;
      send_request(OP_QUERY, 4'd3, '0, '0, '0, 1'b0);    // type not found
      send_request(OP_REPORT, 4'd3, '0, '0, '0, 1'b1);
      send_request(OP_CANCEL, 4'd3, '0, '0, '0, 1'b0);
      send_request(OP_ADD, 4'd0, 8'd0, 24'd0, clk_now, 1'b0);
      send_request(OP_ADD, 4'd15, 8'd255, 24'hFFFFFF, clk_now, 1'b0);
      send_request(OP_ADD, 4'd5, 8'd3, 24'd20000, clk_now, 1'b0);
      send_request(OP_REPORT, 4'd5, '0, '0, '0, 1'b1);   // not awaited
      tick(32'd0);                                       // limit zero fails
      tick(32'd0);                                       // running skipped
      send_request(OP_REPORT, 4'd5, '0, '0, '0, 1'b0);
      tick(32'd1);                                       // not yet due
      send_request(OP_REPORT, 4'd15, '0, '0, '0, 1'b1);
      send_request(OP_ADD, 4'd5, 8'd2, 24'd7, clk_now, 1'b0); // replace
      send_request(OP_CLEAR, '0, '0, '0, '0, 1'b0);
      for (int t = 1; t <= 9; t++)                        // fill, then full
         send_request(OP_ADD, 4'(t), 8'd4, 24'd1, clk_now, 1'b0);
      send_request(OP_CANCEL, 4'd2, '0, '0, '0, 1'b0);
      send_request(OP_CLEAR, '0, '0, '0, '0, 1'b0);
      drain();
      write_reg(REG_INTERVAL, 16'hFFFF);
      tick(32'd10);                                      // throttled
      tick(32'hFFFF_FFFF);                               // wraps, still throttled
      tick(32'd70000);
      send_request(3'd6, 4'd1, '0, '0, '0, 1'b0);        // unknown op
      send_request(3'd7, 4'd1, '0, '0, '0, 1'b0);
      drain();
   endtask

   // random: a weighted mix of all operations, unknown ones too, mostly over a few types
   task automatic test_random(int count, logic backoff, logic [15:0] ivl, logic [15:0] mask);
      logic [2:0] op;
      int sel;
      write_reg(REG_BACKOFF, {15'd0, backoff});
      write_reg(REG_INTERVAL, ivl);
      write_reg(REG_CRIT, mask);
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 25) op = OP_ADD;
         else if (sel < 50) op = OP_PROCESS;
         else if (sel < 78) op = OP_REPORT;
         else if (sel < 84) op = OP_CANCEL;
         else if (sel < 90) op = OP_CLEAR;
         else if (sel < 97) op = OP_QUERY;
         else op = 3'($urandom_range(6, 7));
         if (op == OP_PROCESS) clk_now = clk_now + $urandom_range(0, 3 * ivl + 5);
         if (sel == 0) clk_now = $urandom;
         send_request(op, ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(5)),
                      ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4)),
                      ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(40000)),
                      ($urandom_range(9) == 0) ? $urandom : clk_now, 1'($urandom));
      end
      drain();
   endtask

   // long receiver hold-off while requests keep coming, then a quiet pause
   task automatic test_backpressure();
      hold_cycles <= 600;
      for (int n = 0; n < 20; n++)
         send_request((n % 2) ? OP_PROCESS : OP_ADD, 4'($urandom), 8'd3, 24'($urandom),
                      clk_now + n * 70000, 1'b0);
      drain();
   endtask

   initial begin
      mismatches = 0;
      cycles = 0;
      hold_cycles = 0;
      tbl_used = 0;
      scan_time = '0;
      cfg_backoff = 1'b0;
      cfg_interval = 16'd1000;
      cfg_crit_mask = '0;
      req.valid = 1'b0;
      req.op = '0;
      req.task_type = '0;
      req.max_attempts = '0;
      req.base_interval = '0;
      req.now = '0;
      req.success = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      rsp.ready = 1'b0;
      reset = 1'b1;
      send_idle_pct = 6;
      recv_idle_pct = 69;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(100, 1'b1, 16'd0, 16'h00F0);
      send_idle_pct = 69;
      recv_idle_pct = 6;
      test_random(100, 1'b0, 16'd200, 16'hFFFF);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(100, 1'b1, 16'd50, 16'h0000);

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
